FILE: hw/rtl/mmfs_pkg.sv
// ----------------------------------------------------------------------------
// mmfs_pkg
// Shared types and constants of the min-max feature scaler.
// ----------------------------------------------------------------------------
package mmfs_pkg;

  localparam int unsigned NUM_ATTRIBUTES_DEF = 256;

  localparam int unsigned ATTR_W   = 8;
  localparam int unsigned SAMPLE_W = 32;
  localparam int unsigned SCALED_W = 18;
  localparam int unsigned QUOT_W   = 17;   // quotient bits of (d << 17) / range

  localparam int unsigned S_TDATA_W = 40;  // attribute + sample_value
  localparam int unsigned M_TDATA_W = 32;  // scaled_value + attribute_out, padded

  // table reset values
  localparam logic [SAMPLE_W-1:0] MIN_RESET = 32'h7FFF_FFFF;
  localparam logic [SAMPLE_W-1:0] MAX_RESET = 32'h0000_0000;

  // Q1.16 results
  localparam logic signed [SCALED_W-1:0] Q_POS_ONE = 18'sd65536;
  localparam logic signed [SCALED_W-1:0] Q_NEG_ONE = -18'sd65536;
  localparam logic signed [SCALED_W-1:0] Q_ZERO    = 18'sd0;

  // request kinds
  localparam logic MODE_OBSERVE = 1'b0;
  localparam logic MODE_SCALE   = 1'b1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_PREP,
    ST_DIV,
    ST_OUT
  } state_t;

endpackage

FILE: hw/rtl/min_max_feature_scaler_unit.sv
// ----------------------------------------------------------------------------
// min_max_feature_scaler_unit
// Per-attribute min/max tracker and scaler to signed Q1.16 in [-1, 1].
// ----------------------------------------------------------------------------
//
//  channel | dir | handshake         | contents
//  --------+-----+-------------------+--------------------------------------
//  s_*     | in  | s_tvalid/s_tready | observe or scale request (tuser=mode)
//  m_*     | out | m_tvalid/m_tready | scaled value + attribute, scale only
//
//  After reset the min and max tables are swept clear, one entry per cycle,
//  with s_tready low. One request is worked on at a time. Observe: table
//  read, then read-modify-write. Scale: table read, range and offset, then
//  the 17-step divider unless a special case settles the result early.
//  The result sits in an output register; a new request is taken while it
//  waits. A scale result stalls in its final state only if the previous
//  result has not been taken.
// ----------------------------------------------------------------------------
module min_max_feature_scaler_unit #(
  parameter int unsigned NUM_ATTRIBUTES = mmfs_pkg::NUM_ATTRIBUTES_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  // [7:0] attribute, [39:8] sample_value (signed Q16.16)
  input  logic [mmfs_pkg::S_TDATA_W-1:0]     s_tdata,
  // [0] mode: 0 observe, 1 scale
  input  logic                               s_tuser,
  output logic                               m_tvalid,
  input  logic                               m_tready,
  // [17:0] scaled_value (signed Q1.16), [25:18] attribute_out, [31:26] zero
  output logic [mmfs_pkg::M_TDATA_W-1:0]     m_tdata
);

  localparam int unsigned AW  = (NUM_ATTRIBUTES > 1) ? $clog2(NUM_ATTRIBUTES) : 1;
  localparam int unsigned XW  = mmfs_pkg::SAMPLE_W;
  localparam int unsigned AtW = mmfs_pkg::ATTR_W;
  localparam int unsigned RW  = mmfs_pkg::SCALED_W;
  localparam int unsigned QW  = mmfs_pkg::QUOT_W;

  mmfs_pkg::state_t state, state_next;

  // request registers
  logic                 in_mode;
  logic [AtW-1:0]       in_attr;
  logic [XW-1:0]        in_x;
  logic                 in_valid;

  // scale intermediates: 33-bit signed differences
  logic signed [XW:0]   range_q;
  logic signed [XW:0]   diff_q;
  logic signed [XW:0]   range_c;
  logic signed [XW:0]   diff_c;
  logic                 early;
  logic signed [RW-1:0] early_val;
  logic signed [RW-1:0] res_value;

  logic [AW-1:0]        clr_addr;

  // table ports
  logic                 accept;
  logic [AW-1:0]        raddr;
  logic [XW-1:0]        rd_min, rd_max;
  logic                 min_we, max_we;
  logic [AW-1:0]        waddr;
  logic [XW-1:0]        min_wdata, max_wdata;

  logic                 div_start, div_done;
  logic [QW-1:0]        quotient;
  logic                 out_load;

  assign accept = s_tvalid && s_tready;
  assign raddr  = AW'(s_tdata[AtW-1:0]);

  mmfs_ram #(.WIDTH(XW), .DEPTH(NUM_ATTRIBUTES)) u_min_ram (
    .clk   (clk),
    .we    (min_we),
    .waddr (waddr),
    .wdata (min_wdata),
    .re    (accept),
    .raddr (raddr),
    .rdata (rd_min)
  );

  mmfs_ram #(.WIDTH(XW), .DEPTH(NUM_ATTRIBUTES)) u_max_ram (
    .clk   (clk),
    .we    (max_we),
    .waddr (waddr),
    .wdata (max_wdata),
    .re    (accept),
    .raddr (raddr),
    .rdata (rd_max)
  );

  mmfs_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (diff_q[XW-1:0]),
    .divisor  (range_q[XW-1:0]),
    .done     (div_done),
    .quotient (quotient)
  );

  // range = max - min, d = x - min, exact in 33 bits
  assign range_c = $signed({rd_max[XW-1], rd_max}) - $signed({rd_min[XW-1], rd_min});
  assign diff_c  = $signed({in_x[XW-1], in_x})     - $signed({rd_min[XW-1], rd_min});

  // Special cases settle without the divider:
  // out-of-table attribute or empty range -> 0, at/below min -> -1, at/above max -> +1
  always_comb begin
    early     = 1'b1;
    early_val = mmfs_pkg::Q_ZERO;
    if (!in_valid || range_q <= 0) begin
      early_val = mmfs_pkg::Q_ZERO;
    end else if (diff_q <= 0) begin
      early_val = mmfs_pkg::Q_NEG_ONE;
    end else if (diff_q >= range_q) begin
      early_val = mmfs_pkg::Q_POS_ONE;
    end else begin
      early = 1'b0;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      mmfs_pkg::ST_CLEAR: begin
        if (clr_addr == AW'(NUM_ATTRIBUTES - 1)) state_next = mmfs_pkg::ST_IDLE;
      end
      mmfs_pkg::ST_IDLE: begin
        if (s_tvalid) state_next = mmfs_pkg::ST_READ;
      end
      mmfs_pkg::ST_READ: begin
        if (in_mode == mmfs_pkg::MODE_OBSERVE) state_next = mmfs_pkg::ST_IDLE;
        else state_next = mmfs_pkg::ST_PREP;
      end
      mmfs_pkg::ST_PREP: begin
        state_next = early ? mmfs_pkg::ST_OUT : mmfs_pkg::ST_DIV;
      end
      mmfs_pkg::ST_DIV: begin
        if (div_done) state_next = mmfs_pkg::ST_OUT;
      end
      mmfs_pkg::ST_OUT: begin
        if (!m_tvalid || m_tready) state_next = mmfs_pkg::ST_IDLE;
      end
      default: state_next = mmfs_pkg::ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    s_tready  = 1'b0;
    min_we    = 1'b0;
    max_we    = 1'b0;
    waddr     = AW'(in_attr);
    min_wdata = in_x;
    max_wdata = in_x;
    div_start = 1'b0;
    out_load  = 1'b0;
    unique case (state)
      mmfs_pkg::ST_CLEAR: begin
        min_we    = 1'b1;
        max_we    = 1'b1;
        waddr     = clr_addr;
        min_wdata = mmfs_pkg::MIN_RESET;
        max_wdata = mmfs_pkg::MAX_RESET;
      end
      mmfs_pkg::ST_IDLE: begin
        s_tready = 1'b1;
      end
      mmfs_pkg::ST_READ: begin
        // strict compares: equal values leave the entry alone
        if (in_mode == mmfs_pkg::MODE_OBSERVE && in_valid) begin
          min_we = $signed(in_x) < $signed(rd_min);
          max_we = $signed(in_x) > $signed(rd_max);
        end
      end
      mmfs_pkg::ST_PREP: begin
        div_start = !early;
      end
      mmfs_pkg::ST_DIV: begin
      end
      mmfs_pkg::ST_OUT: begin
        out_load = !m_tvalid || m_tready;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= mmfs_pkg::ST_CLEAR;
      clr_addr <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == mmfs_pkg::ST_CLEAR) clr_addr <= clr_addr + 1'b1;
      if (out_load) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      in_mode  <= s_tuser;
      in_attr  <= s_tdata[AtW-1:0];
      in_x     <= s_tdata[AtW +: XW];
      in_valid <= (32'(s_tdata[AtW-1:0]) < NUM_ATTRIBUTES);
    end
    if (state == mmfs_pkg::ST_READ) begin
      range_q <= range_c;
      diff_q  <= diff_c;
    end
    if (state == mmfs_pkg::ST_PREP) begin
      res_value <= early_val;
    end else if (state == mmfs_pkg::ST_DIV && div_done) begin
      res_value <= $signed({1'b0, quotient}) - mmfs_pkg::Q_POS_ONE;
    end
    if (out_load) begin
      m_tdata <= {(mmfs_pkg::M_TDATA_W - RW - AtW)'(0), in_attr, res_value};
    end
  end

endmodule

FILE: hw/rtl/mmfs_ram.sv
// ----------------------------------------------------------------------------
// mmfs_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module mmfs_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 256,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: hw/rtl/mmfs_div.sv
// ----------------------------------------------------------------------------
// mmfs_div
// Restoring divider, one quotient bit per cycle: (dividend << QUOT_W) / divisor.
// Requires dividend < divisor.
// ----------------------------------------------------------------------------
module mmfs_div (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  input  logic [mmfs_pkg::SAMPLE_W-1:0]      dividend,
  input  logic [mmfs_pkg::SAMPLE_W-1:0]      divisor,
  output logic                               done,
  output logic [mmfs_pkg::QUOT_W-1:0]        quotient
);

  localparam int unsigned W   = mmfs_pkg::SAMPLE_W;
  localparam int unsigned QW  = mmfs_pkg::QUOT_W;
  localparam int unsigned CW  = $clog2(QW);

  logic          busy;
  logic [CW-1:0] cnt;
  logic [W-1:0]  rem;
  logic [W-1:0]  dvs;
  logic [W:0]    rem_sh;
  logic          fits;

  assign rem_sh = {rem, 1'b0};
  assign fits   = (rem_sh >= {1'b0, dvs});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CW'(QW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= dividend;
      dvs      <= divisor;
      quotient <= '0;
    end else if (busy) begin
      if (fits) begin
        rem <= W'(rem_sh - {1'b0, dvs});
      end else begin
        rem <= rem_sh[W-1:0];
      end
      quotient <= {quotient[QW-2:0], fits};
    end
  end

endmodule

FILE: dv/mmfs_checker.sv
// ----------------------------------------------------------------------------
// mmfs_checker
// Watches both stream channels of the min-max feature scaler, keeps its own
// min/max tables, predicts each scaled result and compares field by field.
// ----------------------------------------------------------------------------
module mmfs_checker #(
  parameter int unsigned NUM_ATTRIBUTES = mmfs_pkg::NUM_ATTRIBUTES_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  input  logic                           s_tready,
  input  logic [mmfs_pkg::S_TDATA_W-1:0] s_tdata,
  input  logic                           s_tuser,
  input  logic                           m_tvalid,
  input  logic                           m_tready,
  input  logic [mmfs_pkg::M_TDATA_W-1:0] m_tdata,
  input  logic                           wrap_up,
  output int                             fail_count,
  output int                             outstanding,
  output int                             observe_count,
  output int                             scale_count,
  output int                             flat_count,
  output int                             low_clamp_count,
  output int                             high_clamp_count,
  output int                             inside_count
);
  timeunit 1ns;
  timeprecision 1ps;

  import mmfs_pkg::*;

  typedef enum logic [1:0] {
    KIND_FLAT,
    KIND_LOW,
    KIND_HIGH,
    KIND_INSIDE
  } scale_kind_t;

  typedef struct packed {
    logic signed [SCALED_W-1:0] scaled;
    logic        [ATTR_W-1:0]   attr;
  } scaled_result_t;

  logic signed [SAMPLE_W-1:0] col_min [NUM_ATTRIBUTES];
  logic signed [SAMPLE_W-1:0] col_max [NUM_ATTRIBUTES];
  scaled_result_t             scaled_expect_q [$];
  logic                       wrapped;

  task automatic report_mismatch(input string what);
    $display("%0t ns mmfs_checker: MISMATCH %s", $time, what);
    fail_count++;
  endtask

  // (x - min) / (max - min) * 2 - 1 in Q1.16, truncating divide on
  // non-negative operands, clamped at both ends
  function automatic logic signed [SCALED_W-1:0] scale_predict(
    input  logic signed [SAMPLE_W-1:0] x,
    input  logic signed [SAMPLE_W-1:0] lo,
    input  logic signed [SAMPLE_W-1:0] hi,
    output scale_kind_t                kind
  );
    longint          span;
    longint          offset;
    longint unsigned quo;
    longint          res;
    span   = longint'(hi) - longint'(lo);
    offset = longint'(x) - longint'(lo);
    if (span <= 0) begin
      kind = KIND_FLAT;
      return Q_ZERO;
    end
    if (offset <= 0) begin
      kind = KIND_LOW;
      return Q_NEG_ONE;
    end
    if (offset >= span) begin
      kind = KIND_HIGH;
      return Q_POS_ONE;
    end
    kind = KIND_INSIDE;
    quo  = (unsigned'(offset) << QUOT_W) / unsigned'(span);
    res  = longint'(quo) - longint'(Q_POS_ONE);
    return res[SCALED_W-1:0];
  endfunction

  always @(posedge clk) begin : monitor
    scaled_result_t             got;
    scaled_result_t             want;
    scale_kind_t                kind;
    logic [ATTR_W-1:0]          attr;
    logic signed [SAMPLE_W-1:0] sample;
    if (rst) begin
      for (int i = 0; i < NUM_ATTRIBUTES; i++) begin
        col_min[i] = MIN_RESET;
        col_max[i] = MAX_RESET;
      end
      scaled_expect_q.delete();
      wrapped          = 1'b0;
      fail_count       = 0;
      observe_count    = 0;
      scale_count      = 0;
      flat_count       = 0;
      low_clamp_count  = 0;
      high_clamp_count = 0;
      inside_count     = 0;
    end else begin
      // result side first: it always belongs to an older request
      if (m_tvalid && m_tready) begin
        got.scaled = m_tdata[SCALED_W-1:0];
        got.attr   = m_tdata[SCALED_W +: ATTR_W];
        if (m_tdata[M_TDATA_W-1:SCALED_W+ATTR_W] != '0)
          report_mismatch($sformatf("pad bits not zero: %h", m_tdata));
        if (scaled_expect_q.size() == 0) begin
          report_mismatch($sformatf("unexpected result %h", m_tdata));
        end else begin
          want = scaled_expect_q.pop_front();
          if (got.scaled !== want.scaled)
            report_mismatch($sformatf("attr %0d scaled_value got %0d want %0d",
                                      want.attr, got.scaled, want.scaled));
          if (got.attr !== want.attr)
            report_mismatch($sformatf("attribute_out got %0d want %0d",
                                      got.attr, want.attr));
        end
      end

      if (s_tvalid && s_tready) begin
        attr   = s_tdata[ATTR_W-1:0];
        sample = s_tdata[ATTR_W +: SAMPLE_W];
        if (s_tuser == MODE_OBSERVE) begin
          observe_count++;
          if (attr < NUM_ATTRIBUTES) begin
            if (sample < col_min[attr]) col_min[attr] = sample;
            if (sample > col_max[attr]) col_max[attr] = sample;
          end
        end else begin
          scale_count++;
          want.attr = attr;
          if (attr < NUM_ATTRIBUTES) begin
            want.scaled = scale_predict(sample, col_min[attr], col_max[attr], kind);
          end else begin
            // column past the tables: no statistics, plain zero
            want.scaled = Q_ZERO;
            kind        = KIND_FLAT;
          end
          case (kind)
            KIND_FLAT: flat_count++;
            KIND_LOW:  low_clamp_count++;
            KIND_HIGH: high_clamp_count++;
            default:   inside_count++;
          endcase
          scaled_expect_q.push_back(want);
        end
      end

      if (wrap_up && !wrapped) begin
        wrapped = 1'b1;
        if (scaled_expect_q.size() != 0)
          report_mismatch($sformatf("%0d expected results never arrived",
                                    scaled_expect_q.size()));
      end
    end
    outstanding <= scaled_expect_q.size();
  end

endmodule

FILE: dv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Stream-level test of the min-max feature scaler: a directed set of observe
// and scale requests over the clamp, empty-range and full-scale corners, then
// random request traffic with random gaps and back-pressure, checked against
// an independent prediction in mmfs_checker.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import mmfs_pkg::*;

  localparam int IDLE_PCT       = 30;
  localparam int QUIET_LIMIT    = 4000;  // clear sweep + divide + stalls, with margin
  localparam int TAIL_CYCLES    = 40;
  localparam int HOT_SLOTS      = 8;

  logic                   clk;
  logic                   rst      = 1'b1;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [S_TDATA_W-1:0]   s_tdata  = '0;   // [7:0] attribute, [39:8] sample_value
  logic                   s_tuser  = 1'b0; // [0] mode
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [M_TDATA_W-1:0]   m_tdata;         // [17:0] scaled, [25:18] attribute, pad
  logic                   wrap_up  = 1'b0;

  int fail_count;
  int outstanding;
  int observe_count;
  int scale_count;
  int flat_count;
  int low_clamp_count;
  int high_clamp_count;
  int inside_count;

  int tx_idle_pct  = IDLE_PCT;
  int rx_stall_pct = IDLE_PCT;
  int quiet_cycles = 0;

  // a few hot columns get most of the traffic so their tables fill up and
  // scale requests land inside real ranges
  logic [ATTR_W-1:0]   hot_attr   [HOT_SLOTS];
  logic [SAMPLE_W-1:0] hot_base   [HOT_SLOTS];
  logic [SAMPLE_W-1:0] hot_recent [HOT_SLOTS];

  min_max_feature_scaler_unit u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  mmfs_checker u_checker (
    .clk              (clk),
    .rst              (rst),
    .s_tvalid         (s_tvalid),
    .s_tready         (s_tready),
    .s_tdata          (s_tdata),
    .s_tuser          (s_tuser),
    .m_tvalid         (m_tvalid),
    .m_tready         (m_tready),
    .m_tdata          (m_tdata),
    .wrap_up          (wrap_up),
    .fail_count       (fail_count),
    .outstanding      (outstanding),
    .observe_count    (observe_count),
    .scale_count      (scale_count),
    .flat_count       (flat_count),
    .low_clamp_count  (low_clamp_count),
    .high_clamp_count (high_clamp_count),
    .inside_count     (inside_count)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // result side back-pressure, random per cycle
  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= rx_stall_pct);
  end

  // watchdog: too long with no handshake on either side ends the run
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("testbench: done, errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // One request. Called at a clock edge; returns at the edge that takes it.
  // tvalid stays high into the next call unless a gap is drawn there.
  task automatic send_request(input logic mode, input logic [ATTR_W-1:0] attr,
                              input logic [SAMPLE_W-1:0] value);
    int gap;
    if ($urandom_range(99) < tx_idle_pct) begin
      gap = $urandom_range(1, 5);
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= mode;
    s_tdata  <= {value, attr};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  // hold off until every scale result has been taken
  task automatic drain_results();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  function automatic logic [SAMPLE_W-1:0] pick_sample(input int slot);
    int pick;
    int spread;
    pick = $urandom_range(99);
    if (pick < 25) begin
      return $urandom;                        // any bit pattern
    end else if (pick < 70) begin
      spread = $urandom_range(0, 1 << 19);    // near the column's working point
      return hot_base[slot] + SAMPLE_W'(spread - (1 << 18));
    end else if (pick < 85) begin
      case ($urandom_range(4))
        0:       return 32'h8000_0000;
        1:       return 32'h7FFF_FFFF;
        2:       return 32'hFFFF_FFFF;
        3:       return 32'h0000_0001;
        default: return 32'h0000_0000;
      endcase
    end else begin
      return hot_recent[slot];                // repeats the last value observed through this slot
    end
  endfunction

  task automatic random_requests(input int count);
    int                  slot;
    logic                mode;
    logic [ATTR_W-1:0]   attr;
    logic [SAMPLE_W-1:0] value;
    for (int n = 0; n < count; n++) begin
      slot  = $urandom_range(HOT_SLOTS - 1);
      attr  = ($urandom_range(99) < 75) ? hot_attr[slot] : ATTR_W'($urandom);
      mode  = ($urandom_range(99) < 40) ? MODE_OBSERVE : MODE_SCALE;
      value = pick_sample(slot);
      if (mode == MODE_OBSERVE) hot_recent[slot] = value;
      send_request(mode, attr, value);
    end
  endtask

  initial begin
    for (int i = 0; i < HOT_SLOTS; i++) begin
      hot_attr[i]   = ATTR_W'($urandom);
      hot_base[i]   = $urandom_range(0, 1) ? 32'($urandom_range(0, 1 << 24))
                                           : -32'($urandom_range(0, 1 << 24));
      hot_recent[i] = hot_base[i];
    end

    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // ---- directed corners ---------------------------------------------------
    // untouched column: min above max, inverted range gives zero
    send_request(MODE_SCALE,   8'd0,   32'h0005_0000);
    // single observation of zero: empty range
    send_request(MODE_OBSERVE, 8'd0,   32'h0000_0000);
    send_request(MODE_SCALE,   8'd0,   32'h0000_0000);
    // range [0, 10.0]: midpoint, quarter, below, on min, on max, above
    send_request(MODE_OBSERVE, 8'd0,   32'h000A_0000);
    send_request(MODE_SCALE,   8'd0,   32'h0005_0000);
    send_request(MODE_SCALE,   8'd0,   32'h0002_8000);
    send_request(MODE_SCALE,   8'd0,   32'hFFFD_0000);
    send_request(MODE_SCALE,   8'd0,   32'h0000_0000);
    send_request(MODE_SCALE,   8'd0,   32'h000A_0000);
    send_request(MODE_SCALE,   8'd0,   32'h0014_0000);
    // repeat of the max changes nothing
    send_request(MODE_OBSERVE, 8'd0,   32'h000A_0000);
    // top column over the full sample range
    send_request(MODE_OBSERVE, 8'd255, 32'h8000_0000);
    send_request(MODE_OBSERVE, 8'd255, 32'h7FFF_FFFF);
    send_request(MODE_SCALE,   8'd255, 32'h8000_0000);
    send_request(MODE_SCALE,   8'd255, 32'h7FFF_FFFF);
    send_request(MODE_SCALE,   8'd255, 32'h0000_0000);
    send_request(MODE_SCALE,   8'd255, 32'hFFFF_FFFF);
    send_request(MODE_SCALE,   8'd255, 32'h0000_0001);
    // negative-only data: the max stays at zero
    send_request(MODE_OBSERVE, 8'd1,   32'hFFFB_0000);
    send_request(MODE_SCALE,   8'd1,   32'hFFFD_8000);
    send_request(MODE_SCALE,   8'd1,   32'h7FFF_FFFF);
    // observation equal to the reset min, then a positive single point
    send_request(MODE_OBSERVE, 8'd2,   32'h7FFF_FFFF);
    send_request(MODE_SCALE,   8'd2,   32'h7FFF_FFFF);
    send_request(MODE_OBSERVE, 8'd3,   32'h0000_0001);
    send_request(MODE_SCALE,   8'd3,   32'h0000_0000);

    drain_results();

    // ---- random traffic -----------------------------------------------------
    random_requests(250);

    // long stretch at full rate on both sides
    tx_idle_pct  <= 0;
    rx_stall_pct <= 0;
    random_requests(150);

    drain_results();
    tx_idle_pct  <= IDLE_PCT;
    rx_stall_pct <= IDLE_PCT;
    random_requests(250);

    // ---- wind down ----------------------------------------------------------
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    wrap_up <= 1'b1;
    repeat (2) @(posedge clk);

    $display("summary: %0d observe and %0d scale requests sent through the scaler",
             observe_count, scale_count);
    $display("summary: scale outcomes %0d empty range, %0d low clamp, %0d high clamp, %0d in range",
             flat_count, low_clamp_count, high_clamp_count, inside_count);
    if (fail_count == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule

FILE: filelist.f
hw/rtl/mmfs_pkg.sv
hw/rtl/mmfs_ram.sv
hw/rtl/mmfs_div.sv
hw/rtl/min_max_feature_scaler_unit.sv
dv/mmfs_checker.sv
dv/testbench.sv
